>>> rtl/indexed_array_list_engine_core_defines.svh
// assertion macros of the list engine rtl
// no dependencies; included by ialist_ctrl, the one file that carries assertions
`ifndef INDEXED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define INDEXED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define IALIST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define IALIST_NEVER(label, clk, rst_n, cond, msg) \
    `IALIST_ASSERT(label, clk, rst_n, !(cond), msg)

`else

`define IALIST_ASSERT(label, clk, rst_n, prop, msg)
`define IALIST_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/ialist_pkg.sv
// types, codes and sizes of the indexed list engine
// no dependencies; imported by every module of the block
package ialist_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int FOUND_W  = 7;
    localparam int COUNT_W  = 8;
    localparam int FUNC_W   = 3;
    localparam int WORD_W   = 32;
    // common width for position and count compares
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam logic [FUNC_W-1:0] OP_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] OP_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] OP_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] OP_WRITE  = 3'd3;
    localparam logic [FUNC_W-1:0] OP_READ   = 3'd4;
    localparam logic [FUNC_W-1:0] OP_SEARCH = 3'd5;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        word_t             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        status_t            status;
        word_t              read_value;
        logic [FOUND_W-1:0] found_position;
        logic [COUNT_W-1:0] count_after;
    } res_t;

endpackage

>>> rtl/ialist_store.sv
// entry store: one write port, one read port, registered read data
// depends on ialist_pkg
module ialist_store
    import ialist_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output word_t    rdata
);

    word_t mem [CAPACITY];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ialist_ctrl.sv
// request sequencer: range checks, shift and scan walks over the store, live count
// depends on ialist_pkg and the assertion macro header
`include "indexed_array_list_engine_core_defines.svh"

module ialist_ctrl
    import ialist_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] in_func,
    input  word_t             in_value,
    input  logic [POS_W-1:0]  in_position,
    input  logic              out_free,
    output logic              res_valid,
    output res_t              res,
    output mem_req_t          mem_req,
    input  word_t             mem_rdata
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INS  = 7'b0000010,
        S_INSL = 7'b0000100,
        S_DEL  = 7'b0001000,
        S_RDW  = 7'b0010000,
        S_SCAN = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] found_reg, found_next;
    word_t             value_reg, value_next;
    word_t             rd_reg, rd_next;
    status_t           status_reg, status_next;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  found_ext;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  count_dec;
    logic [ADDR_W-1:0] last_idx;
    logic [ADDR_W-1:0] cur_inc;
    logic [ADDR_W-1:0] cur_dec;
    logic              full;
    logic              same_entry;
    logic              walking;

    assign pos_ext   = CMP_W'(in_position);
    assign count_ext = CMP_W'(count_reg);
    assign found_ext = CMP_W'(found_reg);
    assign count_inc = count_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[ADDR_W-1:0];
    assign cur_inc   = cur_reg + ADDR_W'(1);
    assign cur_dec   = cur_reg - ADDR_W'(1);
    assign full      = (count_ext >= CMP_W'(CAPACITY));

    assign in_ready = (state_reg == S_IDLE);

    assign res.status         = status_reg;
    assign res.read_value     = rd_reg;
    assign res.found_position = found_ext[FOUND_W-1:0];
    assign res.count_after    = count_ext[COUNT_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        value_next  = value_reg;
        rd_next     = rd_reg;
        status_next = status_reg;
        mem_req     = '0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next  = in_value;
                    pos_next    = pos_ext[ADDR_W-1:0];
                    status_next = ST_OK;
                    rd_next     = '0;
                    found_next  = '0;
                    state_next  = S_DONE;
                    unique case (in_func)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = count_reg[ADDR_W-1:0];
                                mem_req.wdata = in_value;
                                count_next    = count_inc;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_ext > count_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_ext == count_ext)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = pos_ext[ADDR_W-1:0];
                                mem_req.wdata = in_value;
                                count_next    = count_inc;
                            end
                            else
                            begin
                                // shift up from the top entry down to the position
                                mem_req.re    = 1'b1;
                                mem_req.raddr = last_idx;
                                cur_next      = last_idx;
                                state_next    = S_INS;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (pos_ext >= count_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (pos_ext[ADDR_W-1:0] == last_idx)
                            begin
                                count_next = count_dec;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = pos_ext[ADDR_W-1:0] + ADDR_W'(1);
                                cur_next      = pos_ext[ADDR_W-1:0] + ADDR_W'(1);
                                state_next    = S_DEL;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (pos_ext >= count_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = pos_ext[ADDR_W-1:0];
                                mem_req.wdata = in_value;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_ext >= count_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = pos_ext[ADDR_W-1:0];
                                state_next    = S_RDW;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = '0;
                                cur_next      = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                // data of cur arrives now and moves one place up
                mem_req.we    = 1'b1;
                mem_req.waddr = cur_inc;
                mem_req.wdata = mem_rdata;
                if (cur_reg == pos_reg)
                begin
                    state_next = S_INSL;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = cur_dec;
                    cur_next      = cur_dec;
                end
            end
            S_INSL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = value_reg;
                count_next    = count_inc;
                state_next    = S_DONE;
            end
            S_DEL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cur_dec;
                mem_req.wdata = mem_rdata;
                if (cur_reg == last_idx)
                begin
                    count_next = count_dec;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = cur_inc;
                    cur_next      = cur_inc;
                end
            end
            S_RDW:
            begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (mem_rdata == value_reg)
                begin
                    found_next = cur_reg;
                    state_next = S_DONE;
                end
                else if (cur_reg == last_idx)
                begin
                    status_next = ST_MISSING;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = cur_inc;
                    cur_next      = cur_inc;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        value_reg  <= value_next;
        rd_reg     <= rd_next;
        status_reg <= status_next;
    end

    assign same_entry = mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr);
    assign walking    = (state_reg == S_INS) || (state_reg == S_DEL) || (state_reg == S_SCAN);

    `IALIST_ASSERT(a_count_cap, clk, rst_n, count_reg <= CNT_W'(CAPACITY), "count too high")
    `IALIST_NEVER(a_rw_clash, clk, rst_n, same_entry, "read and write of one entry")
    `IALIST_ASSERT(a_one_at_a_time, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "busy")
    `IALIST_ASSERT(a_walk_in_list, clk, rst_n, walking |-> (CNT_W'(cur_reg) < count_reg), "walk")

endmodule

>>> rtl/indexed_array_list_engine_core.sv
// Indexed list engine: an ordered list of up to 128 signed 32-bit words kept in one
// single-port-write, registered-read memory, with a live entry count. Each request
// (append, insert, delete, overwrite, read, search) gives exactly one result. Append,
// overwrite and out-of-range or full requests go straight to the result state; read
// passes a read-wait state first; insert and delete walk the entries to be shifted,
// one entry per cycle through the memory's read and write ports, and insert then
// writes the new value at its position; search scans from position 0 at one entry per
// cycle up to the first match or the last live entry. Only one request is in flight;
// a finished result sits in an output register, so the next request is taken while
// it waits. No clearing pass is needed after reset.
// depends on ialist_pkg, ialist_store and ialist_ctrl
module indexed_array_list_engine_core
    import ialist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], position [39:32]
    input  logic [2:0]  s_tuser,   // func [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_value [31:0], found_position [38:32],
                                   // count_after [46:39], zero [47]
    output logic [1:0]  m_tuser    // status [1:0]
);

    mem_req_t mem_req;
    word_t    mem_rdata;
    res_t     res;
    logic     res_valid;
    logic     out_free;
    logic     out_valid_reg;
    res_t     out_res_reg;

    ialist_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    ialist_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (s_tuser),
        .in_value    (s_tdata[31:0]),
        .in_position (s_tdata[39:32]),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    // output slot free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {1'b0, out_res_reg.count_after, out_res_reg.found_position,
                       out_res_reg.read_value};

endmodule

>>> tb/sv/ialist_result_check.sv
// result checker for the indexed list engine: watches both stream channels,
// predicts each result from the accepted requests and compares field by field
// depends on ialist_pkg
module ialist_result_check
    import ialist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], position [39:32]
    input  logic [2:0]  s_tuser,   // func [2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // read_value [31:0], found_position [38:32],
                                   // count_after [46:39], zero [47]
    input  logic [1:0]  m_tuser,   // status [1:0]
    output int          fail_count,
    output int          waiting,
    output int          compared
);

    word_t list_words [CAPACITY];
    int    list_len = 0;
    res_t  pending_results [$];
    int    n_fail = 0;
    int    n_cmp = 0;

    // applies one request to the shadow list and returns the result it gives
    function automatic res_t apply_request(input logic [FUNC_W-1:0] op, input word_t val,
                                           input logic [POS_W-1:0] at);
        res_t r;
        int   k;
        bit   hit;
        r.status         = ST_OK;
        r.read_value     = '0;
        r.found_position = '0;
        hit              = 1'b0;
        case (op)
            OP_APPEND:
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_words[list_len] = val;
                    list_len++;
                end
            OP_INSERT:
                if (at > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (k = list_len; k > at; k--)
                        list_words[k] = list_words[k-1];
                    list_words[at] = val;
                    list_len++;
                end
            OP_DELETE:
                if (at >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (k = at; k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            OP_WRITE:
                if (at >= list_len)
                    r.status = ST_RANGE;
                else
                    list_words[at] = val;
            OP_READ:
                if (at >= list_len)
                    r.status = ST_RANGE;
                else
                    r.read_value = list_words[at];
            OP_SEARCH:
            begin
                r.status = ST_MISSING;
                // lowest matching position wins
                for (k = 0; k < list_len; k++)
                begin
                    if (!hit && list_words[k] == val)
                    begin
                        hit              = 1'b1;
                        r.status         = ST_OK;
                        r.found_position = FOUND_W'(k);
                    end
                end
            end
            default:
                ;
        endcase
        r.count_after = COUNT_W'(list_len);
        return r;
    endfunction

    always @(posedge clk)
    begin : chan_watch
        res_t seen;
        res_t want;
        if (rst_n)
        begin
            // results first, so a request taken at the same edge queues behind
            if (m_tvalid && m_tready)
            begin
                seen.status         = status_t'(m_tuser);
                seen.read_value     = m_tdata[31:0];
                seen.found_position = m_tdata[38:32];
                seen.count_after    = m_tdata[46:39];
                if (pending_results.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result: status %0d read %0d found %0d count %0d",
                                 seen.status, seen.read_value, seen.found_position,
                                 seen.count_after);
                end
                else
                begin
                    want = pending_results.pop_front();
                    n_cmp++;
                    if (seen !== want || m_tdata[47] !== 1'b0)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                        begin
                            $display("mismatch on result %0d: expected status %0d read %0d found %0d count %0d",
                                     n_cmp, want.status, want.read_value, want.found_position,
                                     want.count_after);
                            $display("    got status %0d read %0d found %0d count %0d pad %b",
                                     seen.status, seen.read_value, seen.found_position,
                                     seen.count_after, m_tdata[47]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_request(s_tuser, s_tdata[31:0],
                                                        s_tdata[39:32]));
        end
        fail_count <= n_fail;
        waiting    <= pending_results.size();
        compared   <= n_cmp;
    end

endmodule

>>> tb/sv/tb_top.sv
// top of the indexed list engine testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict
// depends on ialist_pkg, indexed_array_list_engine_core and ialist_result_check
module tb_top;
    import ialist_pkg::*;

    // codes with no operation: the block answers them without touching the list
    localparam logic [FUNC_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] OP_SPARE_B = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_ITEMS = 600;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // value [31:0], position [39:32]
    logic [2:0]  s_tuser = '0;   // func [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // read_value [31:0], found_position [38:32],
                                 // count_after [46:39], zero [47]
    logic [1:0]  m_tuser;        // status [1:0]

    int fail_count;
    int waiting;
    int compared;

    int    tx_gap_pct = 12;
    int    rx_stall_pct = 85;
    int    fill = 0;
    int    full_hits = 0;
    int    quiet = 0;
    int    op_sent [8];
    bit    growing = 1'b1;
    word_t value_pool [16];

    always #1 clk = ~clk;

    indexed_array_list_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ialist_result_check u_result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .waiting    (waiting),
        .compared   (compared)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_stall_pct);

    // ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_request(input logic [FUNC_W-1:0] op, input word_t val,
                                input logic [POS_W-1:0] at);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {8'($urandom), $urandom};
            s_tuser  <= 3'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {at, val};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        op_sent[op]++;
        // track the live count so positions can be aimed at the list
        case (op)
            OP_APPEND:
                if (fill < CAPACITY)
                    fill++;
                else
                    full_hits++;
            OP_INSERT:
                if (at <= fill)
                begin
                    if (fill < CAPACITY)
                        fill++;
                    else
                        full_hits++;
                end
            OP_DELETE:
                if (at < fill)
                    fill--;
            default:
                ;
        endcase
    endtask

    task automatic random_request();
        logic [FUNC_W-1:0] op;
        word_t             val;
        logic [POS_W-1:0]  at;
        int                r;
        r = $urandom_range(99);
        if (growing)
            op = (r < 40) ? OP_APPEND : (r < 75) ? OP_INSERT : (r < 82) ? OP_DELETE :
                 (r < 87) ? OP_WRITE : (r < 93) ? OP_READ : (r < 99) ? OP_SEARCH : OP_SPARE_A;
        else
            op = (r < 6) ? OP_APPEND : (r < 12) ? OP_INSERT : (r < 65) ? OP_DELETE :
                 (r < 75) ? OP_WRITE : (r < 85) ? OP_READ : (r < 99) ? OP_SEARCH : OP_SPARE_A;
        if (op == OP_SPARE_A && $urandom_range(1))
            op = OP_SPARE_B;

        // pooled values keep searches hitting and duplicates around
        if ($urandom_range(99) < ((op == OP_SEARCH) ? 80 : 50))
            val = value_pool[$urandom_range(15)];
        else
            val = word_t'($urandom);
        if ($urandom_range(49) == 0)
            value_pool[$urandom_range(15, 4)] = word_t'($urandom);

        r = $urandom_range(99);
        if (r < 85)
        begin
            if (op == OP_INSERT)
                at = POS_W'($urandom_range(fill));
            else if (fill > 0)
                at = POS_W'($urandom_range(fill - 1));
            else
                at = '0;
        end
        else if (r < 93)
            at = POS_W'((op == OP_INSERT && fill < CAPACITY) ? fill + 1 : fill);
        else if (r < 97)
            at = POS_W'(CAPACITY);
        else
            at = POS_W'($urandom_range(CAPACITY));

        push_request(op, val, at);

        if (growing && fill == CAPACITY && $urandom_range(7) == 0)
            growing = 1'b0;
        else if (!growing && fill < 4 && $urandom_range(3) == 0)
            growing = 1'b1;
        else if ($urandom_range(199) == 0)
            growing = !growing;
    endtask

    initial
    begin
        int i;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (i = 4; i < 16; i++)
            value_pool[i] = word_t'($urandom);
        for (i = 0; i < 8; i++)
            op_sent[i] = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty list: everything positional is out of range, search misses
        push_request(OP_READ, 32'sd5, 8'd0);
        push_request(OP_DELETE, 32'sd5, 8'd0);
        push_request(OP_WRITE, 32'sd5, 8'd0);
        push_request(OP_SEARCH, 32'sd0, 8'd0);
        push_request(OP_INSERT, 32'sd9, 8'd1);
        push_request(OP_SPARE_A, word_t'($urandom), 8'd0);
        // build a short list through every growth path
        push_request(OP_INSERT, 32'sh8000_0000, 8'd0);
        push_request(OP_APPEND, 32'sh7fff_ffff, 8'd0);
        push_request(OP_APPEND, -32'sd1, 8'd0);
        push_request(OP_INSERT, 32'sd0, 8'd3);
        push_request(OP_INSERT, 32'sh5555_5555, 8'd1);
        push_request(OP_READ, 32'sd0, 8'd4);
        push_request(OP_READ, 32'sd0, 8'd5);
        push_request(OP_WRITE, 32'shAAAA_AAAA, 8'd0);
        push_request(OP_APPEND, 32'sh7fff_ffff, 8'd0);
        // duplicate value: the lower position must be returned
        push_request(OP_SEARCH, 32'sh7fff_ffff, 8'd0);
        push_request(OP_SEARCH, 32'sh1234_5678, 8'd0);
        push_request(OP_READ, 32'sd0, 8'd128);
        push_request(OP_INSERT, 32'sd3, 8'd128);
        push_request(OP_DELETE, 32'sd0, 8'd0);
        push_request(OP_DELETE, 32'sd0, 8'd4);
        push_request(OP_SPARE_B, word_t'($urandom), 8'd255);
        push_request(OP_DELETE, 32'sd0, 8'd4);

        for (i = 0; i < PHASE_ITEMS; i++)
            random_request();
        tx_gap_pct   = 85;
        rx_stall_pct = 12;
        for (i = 0; i < PHASE_ITEMS; i++)
            random_request();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        for (i = 0; i < PHASE_ITEMS; i++)
            random_request();
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (waiting != 0);
        repeat (200) @(posedge clk);

        $display("sent %0d append, %0d insert, %0d delete, %0d overwrite, %0d read, %0d search, %0d spare",
                 op_sent[OP_APPEND], op_sent[OP_INSERT], op_sent[OP_DELETE], op_sent[OP_WRITE],
                 op_sent[OP_READ], op_sent[OP_SEARCH], op_sent[OP_SPARE_A] + op_sent[OP_SPARE_B]);
        $display("growth refused on a full list %0d times; %0d results compared, %0d bad",
                 full_hits, compared, fail_count);
        if (fail_count == 0 && waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
